// File: rtl/bptc_pkg.sv
// bptc_pkg: shared types, register indexes and constants for the compensation core
// no dependencies
package bptc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 48;

    localparam logic [CfgIdxW-1:0] REG_AC_FIRST  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_AC_SECOND = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_B_ONE     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_B_TWO     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_M_C       = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_M_D       = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_OSS       = 3'd6;

    // divider steps per stage
    localparam int DivStep   = 4;
    localparam int DivStages = 32 / DivStep;
    // divider sideband: up, x1 and two flags for the temperature divide
    localparam int DivSideW  = 24 + 32 + 2;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [23:0] raw_press_word;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic signed [31:0] pressure_pa;
        logic               div_zero;
    } t_out;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } t_cal;

    // state carried through one restoring divider stage
    typedef struct packed {
        logic [31:0] num;   // dividend, shifts into quotient
        logic [31:0] rem;
        logic [31:0] den;
    } t_div;

    function automatic t_div div_steps(input t_div d);
        t_div  r;
        logic [32:0] t;
        r = d;
        for (int k = 0; k < DivStep; k++) begin
            t = {r.rem, r.num[31]};
            r.num = {r.num[30:0], 1'b0};
            if (t >= {1'b0, r.den}) begin
                r.rem = 32'(t - {1'b0, r.den});
                r.num[0] = 1'b1;
            end else begin
                r.rem = t[31:0];
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/baro_pressure_temp_compensation_core.sv
// baro_pressure_temp_compensation_core: pipelined integer temperature and pressure
// compensation; depends on bptc_pkg, bptc_cfg, bptc_div_pipe
// 28 register stages in all; the two 8-stage dividers are fully pipelined
// throughput one request per cycle while the pipe is not frozen by a stall
// stall freezes the whole pipe; a one-entry skid register takes the request in flight
// reset (synchronous, active low) clears valid bits and loads oss 3, other cal 0
module baro_pressure_temp_compensation_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  bptc_pkg::t_in                 i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output bptc_pkg::t_out                o_data,
    input  logic                          i_cfg_we,
    input  logic [bptc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bptc_pkg::CfgDataW-1:0] i_cfg_data
);
    bptc_pkg::t_cal cal;

    bptc_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_cal(cal)
    );

    // pipe advances when output register is free or being drained
    logic en;
    assign en = !o_valid || !i_stall;

    // input skid: holds a request that arrives while the pipe is frozen
    logic          r_skid_v;
    bptc_pkg::t_in r_skid;
    logic          acc;
    logic          p_v;
    bptc_pkg::t_in p_d;

    assign o_stall = r_skid_v;
    assign acc     = i_valid && !o_stall;
    assign p_v     = r_skid_v || acc;
    assign p_d     = r_skid_v ? r_skid : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end else if (acc) begin
            r_skid_v <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (acc && !en) r_skid <= i_data;
    end

    // stage 1: up and ut - ac6
    logic        r1_v;
    logic [23:0] r1_up;
    logic [31:0] r1_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= p_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_up <= p_d.raw_press_word >> (4'd8 - {2'b0, cal.oss});
            r1_d  <= {16'd0, p_d.raw_temp} - {16'd0, cal.ac6};
        end
    end

    // stage 2: x1 = ((ut-ac6)*ac5) >> 15; x2 = x1 + md is formed in stage 3
    logic        r2_v;
    logic [23:0] r2_up;
    logic signed [31:0] r2_x1;
    logic [31:0] n2_prod;
    assign n2_prod = 32'(r1_d * {16'd0, cal.ac5});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en)  r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_up <= r1_up;
            r2_x1 <= $signed(n2_prod) >>> 15;
        end
    end

    // stage 3: signed divide setup, mc*2048 / (x1+md) as magnitudes
    logic        r3_v;
    logic [23:0] r3_up;
    logic signed [31:0] r3_x1;
    logic        r3_zero, r3_neg;
    logic [31:0] r3_num, r3_den;
    logic signed [31:0] n3_x2;
    logic signed [31:0] n3_num;
    assign n3_x2  = r2_x1 + 32'(cal.md);
    assign n3_num = 32'(cal.mc) <<< 11;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_up   <= r2_up;
            r3_x1   <= r2_x1;
            r3_zero <= (n3_x2 == 0);
            r3_neg  <= n3_x2[31] ^ n3_num[31];
            r3_num  <= n3_num[31] ? 32'(-n3_num) : n3_num;
            r3_den  <= n3_x2[31]  ? 32'(-n3_x2)  : n3_x2;
        end
    end

    // temperature divider; sideband: up, x1, zero flag, sign
    logic                          td_v;
    logic [31:0]                   td_q;
    logic [bptc_pkg::DivSideW-1:0] td_s;
    bptc_div_pipe u_tdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r3_v),
        .i_num(r3_num), .i_den(r3_zero ? 32'd1 : r3_den),
        .i_side({r3_up, r3_x1, r3_zero, r3_neg}),
        .o_valid(td_v), .o_quot(td_q), .o_side(td_s)
    );

    // stage 4: b5, t, b6
    logic        r4_v, r4_zero;
    logic [23:0] r4_up;
    logic signed [31:0] r4_b6;
    logic [15:0] r4_t;
    logic signed [31:0] n4_q, n4_b5, n4_t8;
    assign n4_q  = td_s[0] ? 32'(-td_q) : td_q;
    assign n4_b5 = $signed(td_s[33:2]) + n4_q;
    assign n4_t8 = (n4_b5 + 32'sd8) >>> 4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en)  r4_v <= td_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_zero <= td_s[1];
            r4_up   <= td_s[57:34];
            r4_b6   <= n4_b5 - 32'sd4000;
            r4_t    <= n4_t8[15:0];
        end
    end

    // stage 5: products of b6
    logic        r5_v, r5_zero;
    logic [23:0] r5_up;
    logic [15:0] r5_t;
    logic signed [31:0] r5_sq, r5_a2, r5_a3;
    logic signed [31:0] n5_bb;
    assign n5_bb = 32'(r4_b6 * r4_b6);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en)  r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_zero <= r4_zero;
            r5_up   <= r4_up;
            r5_t    <= r4_t;
            r5_sq   <= n5_bb >>> 12;
            r5_a2   <= 32'(r4_b6 * 32'(cal.ac2));
            r5_a3   <= 32'(r4_b6 * 32'(cal.ac3));
        end
    end

    // stage 6: products of sq, shifted terms
    logic        r6_v, r6_zero;
    logic [23:0] r6_up;
    logic [15:0] r6_t;
    logic signed [31:0] r6_x1b, r6_x2b, r6_x1c, r6_x2c;
    logic signed [31:0] n6_p2, n6_p1;
    assign n6_p2 = 32'(32'(cal.b2) * r5_sq);
    assign n6_p1 = 32'(32'(cal.b1) * r5_sq);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en)  r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_zero <= r5_zero;
            r6_up   <= r5_up;
            r6_t    <= r5_t;
            r6_x1b  <= n6_p2 >>> 11;
            r6_x2b  <= r5_a2 >>> 11;
            r6_x1c  <= r5_a3 >>> 13;
            r6_x2c  <= n6_p1 >>> 16;
        end
    end

    // stage 7: b3 and the b4 factor
    logic        r7_v, r7_zero;
    logic [23:0] r7_up;
    logic [15:0] r7_t;
    logic signed [31:0] r7_b3;
    logic [31:0] r7_f;
    logic signed [31:0] n7_s, n7_b3n, n7_x3;
    assign n7_s   = ((32'(cal.ac1) <<< 2) + r6_x1b + r6_x2b) <<< cal.oss;
    assign n7_b3n = n7_s + 32'sd2;
    assign n7_x3  = (r6_x1c + r6_x2c + 32'sd2) >>> 2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en)  r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_zero <= r6_zero;
            r7_up   <= r6_up;
            r7_t    <= r6_t;
            // signed divide by 4, truncating toward zero
            r7_b3   <= (n7_b3n + (n7_b3n[31] ? 32'sd3 : 32'sd0)) >>> 2;
            r7_f    <= n7_x3 + 32'sd32768;
        end
    end

    // stage 8: b4 and b7
    logic        r8_v, r8_zero;
    logic [15:0] r8_t;
    logic [31:0] r8_b4, r8_b7;
    logic [31:0] n8_m, n8_up;
    assign n8_m  = 32'({16'd0, cal.ac4} * r7_f);
    assign n8_up = {8'd0, r7_up} - r7_b3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en)  r8_v <= r7_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_zero <= r7_zero;
            r8_t    <= r7_t;
            r8_b4   <= n8_m >> 15;
            r8_b7   <= 32'(n8_up * (32'd50000 >> cal.oss));
        end
    end

    // stage 9: divide setup, zero flag merge
    logic        r9_v, r9_zero, r9_hi;
    logic [15:0] r9_t;
    logic [31:0] r9_num, r9_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en)  r9_v <= r8_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_zero <= r8_zero || (r8_b4 == 32'd0);
            r9_t    <= r8_t;
            r9_hi   <= r8_b7[31];
            r9_num  <= r8_b7[31] ? r8_b7 : {r8_b7[30:0], 1'b0};
            r9_den  <= (r8_b4 == 32'd0) ? 32'd1 : r8_b4;
        end
    end

    // pressure divider; sideband: t, zero flag, high-range flag, upper bits unused
    logic                          pd_v;
    logic [31:0]                   pd_q;
    logic [bptc_pkg::DivSideW-1:0] pd_s;
    bptc_div_pipe u_pdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r9_v),
        .i_num(r9_num), .i_den(r9_den), .i_side({40'd0, r9_t, r9_zero, r9_hi}),
        .o_valid(pd_v), .o_quot(pd_q), .o_side(pd_s)
    );

    // stage 10: p and the square term
    logic        r10_v, r10_zero;
    logic [15:0] r10_t;
    logic signed [31:0] r10_p, r10_pp;
    logic signed [31:0] n10_p, n10_h;
    assign n10_p = pd_s[0] ? {pd_q[30:0], 1'b0} : pd_q;
    assign n10_h = n10_p >>> 8;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (en)  r10_v <= pd_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_zero <= pd_s[1];
            r10_t    <= pd_s[17:2];
            r10_p    <= n10_p;
            r10_pp   <= 32'(n10_h * n10_h);
        end
    end

    // stage 11: constant products
    logic        r11_v, r11_zero;
    logic [15:0] r11_t;
    logic signed [31:0] r11_p, r11_x1, r11_x2;
    logic signed [31:0] n11_a, n11_b;
    assign n11_a = 32'(r10_pp * 32'sd3038);
    assign n11_b = 32'(r10_p * -32'sd7357);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r11_v <= 1'b0;
        else if (en)  r11_v <= r10_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_zero <= r10_zero;
            r11_t    <= r10_t;
            r11_p    <= r10_p;
            r11_x1   <= n11_a >>> 16;
            r11_x2   <= n11_b >>> 16;
        end
    end

    // stage 12: output register
    bptc_pkg::t_out r_out;
    logic           r_ov;
    logic signed [31:0] n12_c;
    assign n12_c = (r11_x1 + r11_x2 + 32'sd3791) >>> 4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= r11_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.div_zero    <= r11_zero;
            r_out.temp_tenths <= r11_zero ? 16'sd0 : r11_t;
            r_out.pressure_pa <= r11_zero ? 32'sd0 : r11_p + n12_c;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

// File: rtl/bptc_cfg.sv
// bptc_cfg: calibration and oversampling register file
// depends on bptc_pkg
module bptc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bptc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bptc_pkg::CfgDataW-1:0] i_cfg_data,
    output bptc_pkg::t_cal                o_cal
);
    bptc_pkg::t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal     <= '0;
            r_cal.oss <= 2'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bptc_pkg::REG_AC_FIRST: begin
                    r_cal.ac1 <= i_cfg_data[47:32];
                    r_cal.ac2 <= i_cfg_data[31:16];
                    r_cal.ac3 <= i_cfg_data[15:0];
                end
                bptc_pkg::REG_AC_SECOND: begin
                    r_cal.ac4 <= i_cfg_data[47:32];
                    r_cal.ac5 <= i_cfg_data[31:16];
                    r_cal.ac6 <= i_cfg_data[15:0];
                end
                bptc_pkg::REG_B_ONE: r_cal.b1  <= i_cfg_data[15:0];
                bptc_pkg::REG_B_TWO: r_cal.b2  <= i_cfg_data[15:0];
                bptc_pkg::REG_M_C:   r_cal.mc  <= i_cfg_data[15:0];
                bptc_pkg::REG_M_D:   r_cal.md  <= i_cfg_data[15:0];
                bptc_pkg::REG_OSS:   r_cal.oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cal = r_cal;
endmodule

// File: rtl/bptc_div_pipe.sv
// bptc_div_pipe: pipelined unsigned 32/32 restoring divider, 8 stages of 4 bits
// carries a sideband word alongside; depends on bptc_pkg
module bptc_div_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [31:0]                   i_num,
    input  logic [31:0]                   i_den,
    input  logic [bptc_pkg::DivSideW-1:0] i_side,
    output logic                          o_valid,
    output logic [31:0]                   o_quot,
    output logic [bptc_pkg::DivSideW-1:0] o_side
);
    bptc_pkg::t_div                r_d [bptc_pkg::DivStages];
    logic [bptc_pkg::DivSideW-1:0] r_s [bptc_pkg::DivStages];
    logic [bptc_pkg::DivStages-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[bptc_pkg::DivStages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= bptc_pkg::div_steps('{num: i_num, rem: 32'd0, den: i_den});
            r_s[0] <= i_side;
            for (int k = 1; k < bptc_pkg::DivStages; k++) begin
                r_d[k] <= bptc_pkg::div_steps(r_d[k-1]);
                r_s[k] <= r_s[k-1];
            end
        end
    end

    assign o_valid = r_v[bptc_pkg::DivStages-1];
    assign o_quot  = r_d[bptc_pkg::DivStages-1].num;
    assign o_side  = r_s[bptc_pkg::DivStages-1];
endmodule

// File: rtl/bptc_checker.sv
// bptc_checker: port-level checks for the compensation core
// depends on bptc_pkg; bound to baro_pressure_temp_compensation_core
module bptc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input bptc_pkg::t_out o_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed under stall");

    // divide fault gives zero results
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.div_zero |-> o_data.temp_tenths == 0 && o_data.pressure_pa == 0)
        else $error("div_zero with nonzero result");

    // input never blocked while the output flows
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || !i_stall |=> !o_stall)
        else $error("stall while pipe moving");

    // input stall only rises after a request was offered
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("stall without a request");

    // no output and no input stall right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid after reset");
endmodule

bind baro_pressure_temp_compensation_core bptc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
